// ===== rtl/core/qni_pkg.sv =====
// Shared types, widths and arithmetic step functions for the quadratic interval core.
package qni_pkg;

	localparam int DATA_W    = 32;
	localparam int FRAC_W    = 16;
	localparam int NUM_W     = 2 * DATA_W;
	localparam int DISC_W    = 2 * DATA_W + 2;
	localparam int ROOT_W    = DISC_W / 2;
	localparam int SQ_STEPS  = ROOT_W;
	localparam int SQREM_W   = ROOT_W + 2;
	localparam int DEN_W     = DATA_W + 2;
	localparam int DIV_STEPS = NUM_W;
	localparam int LANES     = 4;

	// divider lanes
	localparam int LANE_X1 = 0;
	localparam int LANE_X2 = 1;
	localparam int LANE_MN = 2;
	localparam int LANE_AM = 3;

	localparam logic signed [DISC_W-1:0] WORD_MAX =
		{{(DISC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
	localparam logic signed [DISC_W-1:0] WORD_MIN =
		{{(DISC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

	typedef logic signed [DATA_W-1:0] word_t;

	typedef struct packed {
		word_t coef_const;
		word_t coef_lin;
		word_t coef_quad;
		word_t domain_begin;
		word_t domain_end;
	} in_item_t;

	typedef struct packed {
		logic  has_interval;
		word_t interval_begin;
		word_t interval_end;
		word_t minimum_value;
		word_t argmin_value;
		logic  degenerate;
		logic  saturated;
	} out_item_t;

	typedef struct packed {
		word_t            c0;
		word_t            c1;
		word_t            c2;
		word_t            db;
		word_t            de;
		logic [NUM_W-1:0] sq1;
	} carry_t;

	typedef struct packed {
		carry_t                    c;
		logic signed [DISC_W-1:0] disc;
	} front_t;

	typedef struct packed {
		carry_t             c;
		logic               has;
		logic [DISC_W-1:0]  rad;
		logic [SQREM_W-1:0] rem;
		logic [ROOT_W-1:0]  root;
	} sq_t;

	typedef struct packed {
		logic [DEN_W-1:0] rem;
		logic [NUM_W-1:0] nq;
		logic [DEN_W-1:0] den;
		logic             neg;
	} div_lane_t;

	typedef struct packed {
		div_lane_t [LANES-1:0] lane;
		logic                  has;
		logic                  degen;
		word_t                 c0;
		word_t                 db;
		word_t                 de;
	} div_t;

	typedef struct packed {
		logic  has;
		logic  degen;
		word_t x1;
		word_t x2;
		word_t db;
		word_t de;
		word_t mn;
		word_t am;
		logic  root_sat;
		logic  val_sat;
	} post_t;

	// one digit of the integer square root: bring down two radicand bits
	function automatic logic [SQREM_W+ROOT_W-1:0] sqrt_step(
		input logic [SQREM_W-1:0] rem,
		input logic [ROOT_W-1:0]  root,
		input logic [1:0]         pair
	);
		logic [SQREM_W+1:0] t;
		logic [SQREM_W+1:0] trial;
		logic [SQREM_W-1:0] rem_n;
		logic [ROOT_W-1:0]  root_n;
		t     = {rem, pair};
		trial = (SQREM_W+2)'({root, 2'b01});
		if (t >= trial) begin
			rem_n  = SQREM_W'(t - trial);
			root_n = {root[ROOT_W-2:0], 1'b1};
		end else begin
			rem_n  = SQREM_W'(t);
			root_n = {root[ROOT_W-2:0], 1'b0};
		end
		return {rem_n, root_n};
	endfunction

	// one restoring division step; quotient bits shift in behind the numerator
	function automatic div_lane_t div_step(input div_lane_t l);
		div_lane_t  r;
		logic [DEN_W:0] t;
		r = l;
		t = {l.rem, l.nq[NUM_W-1]};
		if (t >= {1'b0, l.den}) begin
			r.rem = DEN_W'(t - {1'b0, l.den});
			r.nq  = {l.nq[NUM_W-2:0], 1'b1};
		end else begin
			r.rem = DEN_W'(t);
			r.nq  = {l.nq[NUM_W-2:0], 1'b0};
		end
		return r;
	endfunction

	function automatic logic signed [DISC_W-1:0] signed_q(
		input logic             neg,
		input logic [NUM_W-1:0] q
	);
		logic signed [DISC_W-1:0] m;
		m = $signed({2'b00, q});
		return neg ? -m : m;
	endfunction

	// saturate to the word range; MSB of the result is the clamp flag
	function automatic logic [DATA_W:0] sat_word(input logic signed [DISC_W-1:0] v);
		if (v > WORD_MAX) begin
			return {1'b1, WORD_MAX[DATA_W-1:0]};
		end else if (v < WORD_MIN) begin
			return {1'b1, WORD_MIN[DATA_W-1:0]};
		end
		return {1'b0, v[DATA_W-1:0]};
	endfunction

endpackage

// ===== rtl/core/qni_front.sv =====
// Front stages: coefficient products, then the exact discriminant.
module qni_front import qni_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     adv,
	input  logic     in_valid,
	input  in_item_t in_item,
	output logic     v_out,
	output front_t   f_out
);

	logic                     v_s1, v_s2;
	carry_t                   c_s1;
	logic signed [NUM_W-1:0]  p_s1;
	front_t                   f_s2;
	logic signed [NUM_W-1:0]  sq_w, p_w;

	assign sq_w = in_item.coef_lin * in_item.coef_lin;
	assign p_w  = in_item.coef_quad * in_item.coef_const;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s1.c0  <= in_item.coef_const;
			c_s1.c1  <= in_item.coef_lin;
			c_s1.c2  <= in_item.coef_quad;
			c_s1.db  <= in_item.domain_begin;
			c_s1.de  <= in_item.domain_end;
			c_s1.sq1 <= sq_w;
			p_s1     <= p_w;
			f_s2.c   <= c_s1;
			f_s2.disc <= $signed({2'b00, c_s1.sq1}) - $signed({p_s1, 2'b00});
		end
	end

	assign v_out = v_s2;
	assign f_out = f_s2;

endmodule

// ===== rtl/core/qni_sqrt.sv =====
// Integer square root of the discriminant, one root bit per stage.
module qni_sqrt import qni_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   adv,
	input  logic   v_in,
	input  front_t f_in,
	output logic   v_out,
	output sq_t    sq_out
);

	logic v_s [0:SQ_STEPS-1];
	sq_t  sq_s [0:SQ_STEPS-1];
	sq_t  init;

	always_comb begin
		init.c    = f_in.c;
		init.has  = !f_in.disc[DISC_W-1] && (f_in.disc != '0);
		init.rad  = init.has ? f_in.disc : '0;
		init.rem  = '0;
		init.root = '0;
	end

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_st
		sq_t  prv, nxt;
		logic pv;
		if (k == 0) begin : g_first
			assign prv = init;
			assign pv  = v_in;
		end else begin : g_next
			assign prv = sq_s[k-1];
			assign pv  = v_s[k-1];
		end

		always_comb begin
			nxt      = prv;
			nxt.rad  = prv.rad << 2;
			{nxt.rem, nxt.root} = sqrt_step(prv.rem, prv.root, prv.rad[DISC_W-1 -: 2]);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (adv) begin
				v_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_s[k] <= nxt;
			end
		end
	end

	assign v_out  = v_s[SQ_STEPS-1];
	assign sq_out = sq_s[SQ_STEPS-1];

endmodule

// ===== rtl/core/qni_div.sv =====
// Four-lane restoring divider: operand setup stage, then one quotient bit per stage.
module qni_div import qni_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic v_in,
	input  sq_t  sq_in,
	output logic v_out,
	output div_t d_out
);

	logic v_s [0:DIV_STEPS];
	div_t d_s [0:DIV_STEPS];
	div_t setup;

	logic signed [DATA_W+2:0] nc1, sroot, nx1, nx2;
	logic        [DATA_W+2:0] m1, m2;
	logic        [DATA_W:0]   a1, a2;
	word_t                    c1, c2;

	always_comb begin
		c1    = sq_in.c.c1;
		c2    = sq_in.c.c2;
		nc1   = -$signed({{3{c1[DATA_W-1]}}, c1});
		sroot = $signed({2'b00, sq_in.root});
		nx1   = nc1 - sroot;
		nx2   = nc1 + sroot;
		m1    = nx1[DATA_W+2] ? -nx1 : nx1;
		m2    = nx2[DATA_W+2] ? -nx2 : nx2;
		a1    = c1[DATA_W-1] ? -{c1[DATA_W-1], c1} : {c1[DATA_W-1], c1};
		a2    = c2[DATA_W-1] ? -{c2[DATA_W-1], c2} : {c2[DATA_W-1], c2};

		setup.has   = sq_in.has;
		setup.degen = (c2 == '0);
		setup.c0    = sq_in.c.c0;
		setup.db    = sq_in.c.db;
		setup.de    = sq_in.c.de;

		setup.lane[LANE_X1].nq  = NUM_W'({m1[DATA_W+1:0], {FRAC_W{1'b0}}});
		setup.lane[LANE_X1].den = DEN_W'({a2, 1'b0});
		setup.lane[LANE_X1].neg = nx1[DATA_W+2] ^ c2[DATA_W-1];

		setup.lane[LANE_X2].nq  = NUM_W'({m2[DATA_W+1:0], {FRAC_W{1'b0}}});
		setup.lane[LANE_X2].den = DEN_W'({a2, 1'b0});
		setup.lane[LANE_X2].neg = nx2[DATA_W+2] ^ c2[DATA_W-1];

		setup.lane[LANE_MN].nq  = sq_in.c.sq1;
		setup.lane[LANE_MN].den = DEN_W'({a2, 2'b00});
		setup.lane[LANE_MN].neg = c2[DATA_W-1];

		setup.lane[LANE_AM].nq  = NUM_W'({a1, {FRAC_W{1'b0}}});
		setup.lane[LANE_AM].den = DEN_W'({a2, 1'b0});
		setup.lane[LANE_AM].neg = c1[DATA_W-1] ^ c2[DATA_W-1];

		for (int i = 0; i < LANES; i++) begin
			setup.lane[i].rem = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (adv) begin
			v_s[0] <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s[0] <= setup;
		end
	end

	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_st
		div_t nxt;

		always_comb begin
			nxt = d_s[k-1];
			for (int i = 0; i < LANES; i++) begin
				nxt.lane[i] = div_step(d_s[k-1].lane[i]);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (adv) begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				d_s[k] <= nxt;
			end
		end
	end

	assign v_out = v_s[DIV_STEPS];
	assign d_out = d_s[DIV_STEPS];

endmodule

// ===== rtl/core/qni_post.sv =====
// Result stages: signed quotients and saturation, then sort, clip and output register.
module qni_post import qni_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      adv,
	input  logic      v_in,
	input  div_t      d_in,
	output logic      out_valid,
	output out_item_t out_item
);

	logic      v_s1, v_s2;
	post_t     p_s1;
	out_item_t o_s2;
	post_t     p;
	out_item_t o;

	logic signed [DISC_W-1:0] q_x1, q_x2, q_mn, q_am;
	logic        [DATA_W:0]   s_x1, s_x2, s_mn, s_am;
	word_t                    lo, hi;

	always_comb begin
		q_x1 = d_in.degen ? '0 : signed_q(d_in.lane[LANE_X1].neg, d_in.lane[LANE_X1].nq);
		q_x2 = d_in.degen ? '0 : signed_q(d_in.lane[LANE_X2].neg, d_in.lane[LANE_X2].nq);
		q_mn = d_in.degen ? '0 : signed_q(d_in.lane[LANE_MN].neg, d_in.lane[LANE_MN].nq);
		q_am = d_in.degen ? '0 : signed_q(d_in.lane[LANE_AM].neg, d_in.lane[LANE_AM].nq);
		s_x1 = sat_word(q_x1);
		s_x2 = sat_word(q_x2);
		s_mn = sat_word($signed({{(DISC_W-DATA_W){d_in.c0[DATA_W-1]}}, d_in.c0}) - q_mn);
		s_am = sat_word(-q_am);

		p.has      = d_in.has;
		p.degen    = d_in.degen;
		p.x1       = s_x1[DATA_W-1:0];
		p.x2       = s_x2[DATA_W-1:0];
		p.db       = d_in.db;
		p.de       = d_in.de;
		p.mn       = s_mn[DATA_W-1:0];
		p.am       = s_am[DATA_W-1:0];
		p.root_sat = d_in.has & (s_x1[DATA_W] | s_x2[DATA_W]);
		p.val_sat  = s_mn[DATA_W] | s_am[DATA_W];
	end

	always_comb begin
		lo = (p_s1.x2 < p_s1.x1) ? p_s1.x2 : p_s1.x1;
		hi = (p_s1.x2 < p_s1.x1) ? p_s1.x1 : p_s1.x2;
		o.has_interval   = p_s1.has;
		o.interval_begin = p_s1.has ? ((lo < p_s1.db) ? p_s1.db : lo) : '0;
		o.interval_end   = p_s1.has ? ((hi > p_s1.de) ? p_s1.de : hi) : '0;
		o.minimum_value  = p_s1.mn;
		o.argmin_value   = p_s1.am;
		o.degenerate     = p_s1.degen;
		o.saturated      = p_s1.root_sat | p_s1.val_sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1 <= p;
			o_s2 <= o;
		end
	end

	assign out_valid = v_s2;
	assign out_item  = o_s2;

endmodule

// ===== rtl/core/quadratic_negative_interval_core.sv =====
// Top level of the quadratic root interval and vertex core.
// Stages in order: 2 product/discriminant, 33 square root, 1 divider setup,
// 64 divider and 2 result stages.
// Throughput: one item per cycle; a stalled output freezes the whole pipeline.
// Reset: arst_n clears the stage valid bits only; data registers are not reset.
module quadratic_negative_interval_core import qni_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	// Global advance: every stage moves when the output register is free or
	// being drained. Bubbles travel as cleared valid bits.
	logic   adv;
	logic   v_front, v_sq, v_div;
	front_t f_front;
	sq_t    sq_res;
	div_t   div_res;

	assign adv      = out_ready | ~out_valid;
	assign in_ready = adv;

	// c1^2 and c2*c0 (one 32x32 multiply each), then disc = c1^2 - 4*c2*c0
	qni_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (in_valid),
		.in_item  (in_item),
		.v_out    (v_front),
		.f_out    (f_front)
	);

	// floor sqrt of a positive discriminant; zero radicand otherwise
	qni_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.v_in   (v_front),
		.f_in   (f_front),
		.v_out  (v_sq),
		.sq_out (sq_res)
	);

	// both roots, the vertex offset and the argmin as magnitude quotients
	qni_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.v_in   (v_sq),
		.sq_in  (sq_res),
		.v_out  (v_div),
		.d_out  (div_res)
	);

	// signs, saturation, sort, domain clip, output register
	qni_post u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.v_in      (v_div),
		.d_in      (div_res),
		.out_valid (out_valid),
		.out_item  (out_item)
	);

	// a degenerate quadratic has a zero argmin
	a_degen_argmin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.degenerate |-> out_item.argmin_value == '0)
		else $error("degenerate item with nonzero argmin");

	// with a zero quadratic term nothing can clamp
	a_degen_nosat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.degenerate |-> !out_item.saturated)
		else $error("degenerate item flagged saturated");

	// no interval means zeroed interval fields
	a_no_interval: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.has_interval |->
			out_item.interval_begin == '0 && out_item.interval_end == '0)
		else $error("interval fields set without an interval");

endmodule
